/* rtl/core/crc8fp_pkg.sv */
// Shared types, constants and the CRC-8/ATM byte update for the frame parser.
// No dependencies; used by every module of the parser except crc8fp_ram.
`timescale 1ns / 1ps
`default_nettype none

package crc8fp_pkg;

	localparam logic [7:0] SYNC_FIRST      = 8'hA5;
	localparam logic [7:0] SYNC_SECOND     = 8'h5A;
	localparam logic [7:0] CRC_POLY        = 8'h07;
	localparam logic [3:0] VERSION_RESET   = 4'd4;
	localparam int         MAX_PAYLOAD_DEF = 32;
	localparam int         PIDX_W          = 5;

	// result status codes
	localparam logic [1:0] STAT_GOOD    = 2'd0;
	localparam logic [1:0] STAT_BAD_VER = 2'd1;
	localparam logic [1:0] STAT_BAD_LEN = 2'd2;
	localparam logic [1:0] STAT_BAD_CRC = 2'd3;

	// output register load select
	localparam logic [1:0] OSEL_NONE  = 2'd0;
	localparam logic [1:0] OSEL_ERR   = 2'd1;
	localparam logic [1:0] OSEL_EMPTY = 2'd2;
	localparam logic [1:0] OSEL_PAY   = 2'd3;

	typedef struct packed {
		logic       crc_clr;
		logic       crc_upd;
		logic       vtype_ld;
		logic       seq_ld;
		logic       len_ld;
		logic       pay_wr;
		logic       pos_clr;
		logic       pos_inc;
		logic       rd_en;
		logic [1:0] out_sel;
		logic [1:0] err_code;
	} dp_cmd_t;

	typedef struct packed {
		logic is_sync1;
		logic is_sync2;
		logic ver_ok;
		logic len_ok;
		logic len_byte_zero;
		logic crc_ok;
		logic len_zero;
		logic pay_last;
		logic slot_free;
	} dp_stat_t;

	// CRC-8/ATM, MSB first, one byte
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/crc8_framed_packet_parser.sv */
// Sync A5 5A / header / length / CRC-8/ATM frame parser, top level.
// Latency: an error or empty-frame result is in the output register the cycle after its byte.
// Throughput: one byte per cycle while the output register is free; a good frame's
// payload run reads each result from the registered payload store, input held.
// Reset (arst_n low, async): hunt state, counters, CRC and headers cleared, version = 4.
// The payload store is not cleared; only entries written in the current frame are read.
`timescale 1ns / 1ps
`default_nettype none

module crc8_framed_packet_parser #(
	parameter int MAX_PAYLOAD = crc8fp_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      status,
	output logic [3:0]      version,
	output logic [3:0]      frame_type,
	output logic [7:0]      sequence_res,
	output logic [5:0]      payload_len,
	output logic            has_payload,
	output logic [7:0]      payload_byte,
	output logic [4:0]      payload_index,
	output logic            last
);

	crc8fp_pkg::dp_cmd_t  cmd;
	crc8fp_pkg::dp_stat_t stat;

	// the user must write the version register only while idle; the block does not enforce it
	assign cfg_ready = 1'b1;

	crc8fp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	crc8fp_datapath #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.stat           (stat),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.status         (status),
		.version        (version),
		.frame_type     (frame_type),
		.sequence_res   (sequence_res),
		.payload_len    (payload_len),
		.has_payload    (has_payload),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.last           (last)
	);

endmodule

`default_nettype wire

/* rtl/core/crc8fp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module crc8fp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/crc8fp_datapath.sv */
// Parser datapath: version register, running CRC, header fields, payload store,
// position counter and the result register. Depends on crc8fp_pkg, crc8fp_ram.
`timescale 1ns / 1ps
`default_nettype none

module crc8fp_datapath #(
	parameter int MAX_PAYLOAD = crc8fp_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [3:0]            cfg_data,
	input  wire logic [7:0]            rx_byte,
	input  wire crc8fp_pkg::dp_cmd_t   cmd,
	output crc8fp_pkg::dp_stat_t       stat,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [1:0]                 status,
	output logic [3:0]                 version,
	output logic [3:0]                 frame_type,
	output logic [7:0]                 sequence_res,
	output logic [5:0]                 payload_len,
	output logic                       has_payload,
	output logic [7:0]                 payload_byte,
	output logic [4:0]                 payload_index,
	output logic                       last
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic [3:0] ver_q;
	logic [7:0] crc_q;
	logic [7:0] vtype_q;
	logic [7:0] seq_q;
	logic [5:0] len_q;
	logic [crc8fp_pkg::PIDX_W-1:0] pos_q;
	logic [7:0] crc_next;
	logic [5:0] len_m1;
	logic [7:0] rd_data;
	logic       out_valid_q;

	assign crc_next = crc8fp_pkg::crc8_update(crc_q, rx_byte);
	assign len_m1   = len_q - 6'd1;

	assign stat.is_sync1      = rx_byte == crc8fp_pkg::SYNC_FIRST;
	assign stat.is_sync2      = rx_byte == crc8fp_pkg::SYNC_SECOND;
	assign stat.ver_ok        = rx_byte[7:4] == ver_q;
	assign stat.len_ok        = rx_byte <= 8'(MAX_PAYLOAD);
	assign stat.len_byte_zero = rx_byte == 8'h00;
	assign stat.crc_ok        = crc_q == rx_byte;
	assign stat.len_zero      = len_q == 6'd0;
	assign stat.pay_last      = {1'b0, pos_q} == len_m1;
	assign stat.slot_free     = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q   <= crc8fp_pkg::VERSION_RESET;
			crc_q   <= 8'h00;
			vtype_q <= 8'h00;
			seq_q   <= 8'h00;
			len_q   <= 6'd0;
			pos_q   <= '0;
		end else begin
			if (cfg_valid) begin
				ver_q <= cfg_data;
			end
			if (cmd.crc_clr) begin
				crc_q <= 8'h00;
			end else if (cmd.crc_upd) begin
				crc_q <= crc_next;
			end
			if (cmd.vtype_ld) begin
				vtype_q <= rx_byte;
			end
			if (cmd.seq_ld) begin
				seq_q <= rx_byte;
			end
			if (cmd.len_ld) begin
				len_q <= rx_byte[5:0];
			end
			if (cmd.pos_clr) begin
				pos_q <= '0;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	crc8fp_ram #(
		.WIDTH (8),
		.DEPTH (MAX_PAYLOAD)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.pay_wr),
		.wr_addr (pos_q[AW-1:0]),
		.wr_data (rx_byte),
		.rd_en   (cmd.rd_en),
		.rd_addr (pos_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_sel != crc8fp_pkg::OSEL_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.out_sel)
			crc8fp_pkg::OSEL_ERR: begin
				status         <= cmd.err_code;
				version        <= 4'd0;
				frame_type     <= 4'd0;
				sequence_res   <= 8'd0;
				payload_len    <= 6'd0;
				has_payload    <= 1'b0;
				payload_byte   <= 8'd0;
				payload_index  <= 5'd0;
				last           <= 1'b1;
			end
			crc8fp_pkg::OSEL_EMPTY: begin
				status         <= crc8fp_pkg::STAT_GOOD;
				version        <= vtype_q[7:4];
				frame_type     <= vtype_q[3:0];
				sequence_res   <= seq_q;
				payload_len    <= len_q;
				has_payload    <= 1'b0;
				payload_byte   <= 8'd0;
				payload_index  <= 5'd0;
				last           <= 1'b1;
			end
			crc8fp_pkg::OSEL_PAY: begin
				status         <= crc8fp_pkg::STAT_GOOD;
				version        <= vtype_q[7:4];
				frame_type     <= vtype_q[3:0];
				sequence_res   <= seq_q;
				payload_len    <= len_q;
				has_payload    <= 1'b1;
				payload_byte   <= rd_data;
				payload_index  <= pos_q;
				last           <= stat.pay_last;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/crc8fp_ctrl.sv */
// Parser controller: sync hunt, header/payload/CRC sequencing and payload readout.
// Depends on crc8fp_pkg; drives crc8fp_datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module crc8fp_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire crc8fp_pkg::dp_stat_t  stat,
	output crc8fp_pkg::dp_cmd_t        cmd
);

	localparam logic [3:0] ST_HUNT  = 4'd0;
	localparam logic [3:0] ST_SYNC2 = 4'd1;
	localparam logic [3:0] ST_VTYPE = 4'd2;
	localparam logic [3:0] ST_SEQ   = 4'd3;
	localparam logic [3:0] ST_LEN   = 4'd4;
	localparam logic [3:0] ST_PAY   = 4'd5;
	localparam logic [3:0] ST_CRC   = 4'd6;
	localparam logic [3:0] ST_READ  = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       byte_state;
	logic       acc;
	logic [3:0] resync_st;

	assign byte_state = (state_q == ST_HUNT) || (state_q == ST_SYNC2) ||
	                    (state_q == ST_VTYPE) || (state_q == ST_SEQ) ||
	                    (state_q == ST_LEN) || (state_q == ST_PAY) ||
	                    (state_q == ST_CRC);
	assign in_ready  = byte_state && stat.slot_free;
	assign acc       = in_valid && in_ready;
	// failing byte may open the next frame
	assign resync_st = stat.is_sync1 ? ST_SYNC2 : ST_HUNT;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_HUNT: begin
				if (acc && stat.is_sync1) begin
					state_nxt = ST_SYNC2;
				end
			end
			ST_SYNC2: begin
				if (acc) begin
					if (stat.is_sync2) begin
						cmd.crc_clr = 1'b1;
						state_nxt   = ST_VTYPE;
					end else if (!stat.is_sync1) begin
						state_nxt = ST_HUNT;
					end
				end
			end
			ST_VTYPE: begin
				if (acc) begin
					if (stat.ver_ok) begin
						cmd.vtype_ld = 1'b1;
						cmd.crc_upd  = 1'b1;
						state_nxt    = ST_SEQ;
					end else begin
						cmd.out_sel  = crc8fp_pkg::OSEL_ERR;
						cmd.err_code = crc8fp_pkg::STAT_BAD_VER;
						state_nxt    = resync_st;
					end
				end
			end
			ST_SEQ: begin
				if (acc) begin
					cmd.seq_ld  = 1'b1;
					cmd.crc_upd = 1'b1;
					state_nxt   = ST_LEN;
				end
			end
			ST_LEN: begin
				if (acc) begin
					if (stat.len_ok) begin
						cmd.len_ld  = 1'b1;
						cmd.crc_upd = 1'b1;
						cmd.pos_clr = 1'b1;
						state_nxt   = stat.len_byte_zero ? ST_CRC : ST_PAY;
					end else begin
						cmd.out_sel  = crc8fp_pkg::OSEL_ERR;
						cmd.err_code = crc8fp_pkg::STAT_BAD_LEN;
						state_nxt    = resync_st;
					end
				end
			end
			ST_PAY: begin
				if (acc) begin
					cmd.pay_wr  = 1'b1;
					cmd.pos_inc = 1'b1;
					cmd.crc_upd = 1'b1;
					if (stat.pay_last) begin
						state_nxt = ST_CRC;
					end
				end
			end
			ST_CRC: begin
				if (acc) begin
					if (!stat.crc_ok) begin
						cmd.out_sel  = crc8fp_pkg::OSEL_ERR;
						cmd.err_code = crc8fp_pkg::STAT_BAD_CRC;
						state_nxt    = resync_st;
					end else if (stat.len_zero) begin
						cmd.out_sel = crc8fp_pkg::OSEL_EMPTY;
						state_nxt   = ST_HUNT;
					end else begin
						cmd.pos_clr = 1'b1;
						state_nxt   = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.slot_free) begin
					cmd.out_sel = crc8fp_pkg::OSEL_PAY;
					cmd.pos_inc = 1'b1;
					state_nxt   = stat.pay_last ? ST_HUNT : ST_READ;
				end
			end
			default: begin
				state_nxt = ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/crc8fp_checker.sv */
// Port-level checks for the frame parser, bound to the top level.
// Depends on crc8fp_pkg and crc8_framed_packet_parser.
`timescale 1ns / 1ps
`default_nettype none

module crc8fp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] status,
	input wire logic [3:0] version,
	input wire logic [5:0] payload_len,
	input wire logic       has_payload,
	input wire logic [7:0] payload_byte,
	input wire logic [4:0] payload_index,
	input wire logic       last
);

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_byte)
		&& $stable(payload_index) && $stable(last))
		else $error("stalled result changed");

	// no byte taken while a result is blocked
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted with blocked result");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != crc8fp_pkg::STAT_GOOD |-> last && !has_payload
		&& version == 4'd0 && payload_len == 6'd0)
		else $error("error result malformed");

	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_payload |-> last && payload_index == 5'd0)
		else $error("result without payload not single");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_payload && last |-> payload_len == {1'b0, payload_index} + 6'd1)
		else $error("payload run ends at wrong index");

endmodule

bind crc8_framed_packet_parser crc8fp_checker u_chk (.*);

`default_nettype wire

/* tb/sv/crc8_framed_packet_parser_tb.sv */
// Self-checking bench for crc8_framed_packet_parser: byte stream driver, result monitor,
// built-in frame parse predictor. Depends on crc8fp_pkg and the parser RTL.
`timescale 1ns / 1ps

module crc8_framed_packet_parser_tb;

	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD_CYCLES = 400;

	typedef enum logic [1:0] {HUNT_SYNC1, WAIT_SYNC2, IN_BODY} hunt_state_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] version;
		logic [3:0] frame_type;
		logic [7:0] sequence_res;
		logic [5:0] payload_len;
		logic       has_payload;
		logic [7:0] payload_byte;
		logic [4:0] payload_index;
		logic       last;
	} frame_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [3:0] cfg_data = 4'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;
	logic [3:0] version;
	logic [3:0] frame_type;
	logic [7:0] sequence_res;
	logic [5:0] payload_len;
	logic       has_payload;
	logic [7:0] payload_byte;
	logic [4:0] payload_index;
	logic       last;

	crc8_framed_packet_parser u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.version        (version),
		.frame_type     (frame_type),
		.sequence_res   (sequence_res),
		.payload_len    (payload_len),
		.has_payload    (has_payload),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.last           (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus and expectations
	logic [7:0]    pending_bytes[$];
	frame_result_t predicted_results[$];
	int            frame_bytes = 0;
	int            mismatch_count = 0;
	int            stall_cycles = 0;
	bit            gaps_on = 1'b1;
	int            long_hold_req = 0;
	int            long_hold_seen = 0;
	int            long_hold_left = 0;
	int            tx_gap_left = 0;
	int            rx_stall_left = 0;

	// predictor state
	logic [3:0]  cur_version = crc8fp_pkg::VERSION_RESET;
	hunt_state_t hunt_state = HUNT_SYNC1;
	logic [5:0]  body_pos = '0;
	logic [5:0]  body_end = '0;
	logic [7:0]  body_crc = '0;
	logic [7:0]  hdr_vtype = '0;
	logic [7:0]  hdr_seq = '0;
	logic [5:0]  hdr_len = '0;
	logic [7:0]  pay_store[32];

	function automatic logic [7:0] crc8_atm(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ crc8fp_pkg::CRC_POLY) : {c[6:0], 1'b0};
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// error result, then the offending byte may restart the sync hunt
	function automatic void frame_error(input logic [1:0] code, input logic [7:0] b);
		frame_result_t r;
		r = '0;
		r.status = code;
		r.last = 1'b1;
		predicted_results.push_back(r);
		hunt_state = (b == crc8fp_pkg::SYNC_FIRST) ? WAIT_SYNC2 : HUNT_SYNC1;
		body_pos = '0;
		body_end = '0;
	endfunction

	function automatic void predict_frame_byte(input logic [7:0] b);
		logic [5:0] idx;
		logic [5:0] slot;
		frame_result_t r;
		int n;
		case (hunt_state)
			HUNT_SYNC1: begin
				if (b == crc8fp_pkg::SYNC_FIRST) hunt_state = WAIT_SYNC2;
			end
			WAIT_SYNC2: begin
				if (b == crc8fp_pkg::SYNC_SECOND) begin
					hunt_state = IN_BODY;
					body_pos = '0;
					body_end = '0;
					body_crc = '0;
				end else if (b != crc8fp_pkg::SYNC_FIRST) begin
					hunt_state = HUNT_SYNC1;
				end
			end
			default: begin
				idx = body_pos;
				body_pos = body_pos + 6'd1;
				if (idx == 6'd0) begin
					if (b[7:4] != cur_version) begin
						frame_error(crc8fp_pkg::STAT_BAD_VER, b);
					end else begin
						hdr_vtype = b;
						body_crc = crc8_atm(body_crc, b);
					end
				end else if (idx == 6'd1) begin
					hdr_seq = b;
					body_crc = crc8_atm(body_crc, b);
				end else if (idx == 6'd2) begin
					if (b > crc8fp_pkg::MAX_PAYLOAD_DEF) begin
						frame_error(crc8fp_pkg::STAT_BAD_LEN, b);
					end else begin
						hdr_len = b[5:0];
						body_end = 6'd4 + b[5:0];
						body_crc = crc8_atm(body_crc, b);
					end
				end else if (body_pos < body_end) begin
					slot = idx - 6'd3;
					pay_store[slot[4:0]] = b;
					body_crc = crc8_atm(body_crc, b);
				end else if (body_crc != b) begin
					frame_error(crc8fp_pkg::STAT_BAD_CRC, b);
				end else begin
					n = (hdr_len == 0) ? 1 : hdr_len;
					for (int k = 0; k < n; k++) begin
						r = '0;
						r.status = crc8fp_pkg::STAT_GOOD;
						r.version = hdr_vtype[7:4];
						r.frame_type = hdr_vtype[3:0];
						r.sequence_res = hdr_seq;
						r.payload_len = hdr_len;
						if (hdr_len != 0) begin
							r.has_payload = 1'b1;
							r.payload_byte = pay_store[k];
							r.payload_index = 5'(k);
						end
						r.last = (k == n - 1);
						predicted_results.push_back(r);
					end
					hunt_state = HUNT_SYNC1;
					body_pos = '0;
					body_end = '0;
				end
			end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		frame_bytes++;
	endtask

	// sync, header, payload and CRC; stops early where the parser would reject the frame
	task automatic queue_frame(input logic [7:0] vtype, input logic [7:0] seq,
			input logic [7:0] len_byte, input bit bad_crc);
		logic [7:0] crc;
		logic [7:0] b;
		push_byte(crc8fp_pkg::SYNC_FIRST);
		push_byte(crc8fp_pkg::SYNC_SECOND);
		push_byte(vtype);
		if (vtype[7:4] != cur_version) return;
		crc = crc8_atm(8'h00, vtype);
		push_byte(seq);
		crc = crc8_atm(crc, seq);
		push_byte(len_byte);
		if (len_byte > crc8fp_pkg::MAX_PAYLOAD_DEF) return;
		crc = crc8_atm(crc, len_byte);
		for (int i = 0; i < len_byte; i++) begin
			b = 8'($urandom);
			push_byte(b);
			crc = crc8_atm(crc, b);
		end
		push_byte(bad_crc ? (crc ^ (8'h01 << $urandom_range(0, 7))) : crc);
	endtask

	task automatic queue_random_frames(input int budget);
		int start;
		int r;
		int l;
		logic [7:0] len;
		start = frame_bytes;
		while (frame_bytes - start < budget) begin
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'($urandom));
			l = $urandom_range(0, 99);
			len = (l < 80) ? 8'($urandom_range(0, 6)) :
				(l < 95) ? 8'($urandom_range(7, 31)) : 8'd32;
			r = $urandom_range(0, 99);
			if (r < 65) begin
				queue_frame({cur_version, 4'($urandom)}, 8'($urandom), len, 1'b0);
			end else if (r < 75) begin
				queue_frame({cur_version ^ 4'($urandom_range(1, 15)), 4'($urandom)},
					8'($urandom), len, 1'b0);
			end else if (r < 83) begin
				queue_frame({cur_version, 4'($urandom)}, 8'($urandom),
					8'($urandom_range(33, 255)), 1'b0);
			end else if (r < 93) begin
				queue_frame({cur_version, 4'($urandom)}, 8'($urandom), len, 1'b1);
			end else begin
				// truncated frame: the next frame's bytes land in this body
				push_byte(crc8fp_pkg::SYNC_FIRST);
				push_byte(crc8fp_pkg::SYNC_SECOND);
				repeat ($urandom_range(0, 4)) push_byte(8'($urandom));
			end
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_bytes.size() != 0 || in_valid || predicted_results.size() != 0);
	endtask

	task automatic write_version(input logic [3:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_version = v;
	endtask

	// byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) predict_frame_byte(rx_byte);
			if (!in_valid || in_ready) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					rx_byte <= pending_bytes.pop_front();
					in_valid <= 1'b1;
					tx_gap_left = gaps_on ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver backpressure
	always @(posedge clk) begin
		frame_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					$error("result transaction with nothing expected, status %0d", status);
					mismatch_count++;
				end else begin
					want = predicted_results.pop_front();
					check_field("status", 8'(want.status), 8'(status));
					check_field("version", 8'(want.version), 8'(version));
					check_field("frame_type", 8'(want.frame_type), 8'(frame_type));
					check_field("sequence_res", want.sequence_res, sequence_res);
					check_field("payload_len", 8'(want.payload_len), 8'(payload_len));
					check_field("has_payload", 8'(want.has_payload), 8'(has_payload));
					check_field("payload_byte", want.payload_byte, payload_byte);
					check_field("payload_index", 8'(want.payload_index), 8'(payload_index));
					check_field("last", 8'(want.last), 8'(last));
				end
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				out_ready <= 1'b0;
			end else if (long_hold_seen != long_hold_req) begin
				long_hold_seen = long_hold_req;
				long_hold_left = LONG_HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (!gaps_on) begin
				out_ready <= 1'b1;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				out_ready <= 1'b0;
			end else begin
				rx_stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
				out_ready <= (rx_stall_left == 0);
			end
		end
	end

	// no transaction on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [3:0] versions[5];
		versions[0] = 4'd0;
		versions[1] = 4'd15;
		versions[2] = 4'($urandom_range(1, 14));
		versions[3] = crc8fp_pkg::VERSION_RESET;
		versions[4] = 4'($urandom);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: noise, repeated A5, empty frame, error resyncs, length bounds, bad CRC
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hFF);
		pending_bytes.push_back(crc8fp_pkg::SYNC_FIRST);
		queue_frame({crc8fp_pkg::VERSION_RESET, 4'hF}, 8'hFF, 8'd0, 1'b0);
		push_byte(crc8fp_pkg::SYNC_FIRST);
		push_byte(crc8fp_pkg::SYNC_SECOND);
		push_byte(crc8fp_pkg::SYNC_FIRST);
		push_byte(crc8fp_pkg::SYNC_SECOND);
		push_byte({crc8fp_pkg::VERSION_RESET, 4'h0});
		push_byte(8'h00);
		push_byte(8'hFF);
		queue_frame({crc8fp_pkg::VERSION_RESET, 4'h0}, 8'h00, 8'd33, 1'b0);
		queue_frame({crc8fp_pkg::VERSION_RESET, 4'hA}, 8'h5A, 8'd1, 1'b1);

		for (int p = 0; p < 5; p++) begin
			wait_drained();
			repeat (8) @(posedge clk);
			gaps_on = (p % 2 == 0);
			write_version(versions[p]);
			if (p == 0) queue_frame({cur_version, 4'h0}, 8'h00, 8'd32, 1'b0);
			queue_random_frames(85);
			// output side stalls while bytes keep coming, so the parser backs up
			if (p == 2) long_hold_req++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && predicted_results.size() == 0) begin
			$display("tb: success");
		end else begin
			if (predicted_results.size() != 0)
				$error("%0d expected results never arrived", predicted_results.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule
